/* hdl/mbrtu_pkg.sv */
// Shared types, constants and the CRC step function for the Modbus RTU read slave.
`timescale 1ns / 1ps
`default_nettype none
package mbrtu_pkg;

  // Item codes on the input channel.
  localparam logic [1:0] OP_RX_BYTE   = 2'd0;
  localparam logic [1:0] OP_TICK      = 2'd1;
  localparam logic [1:0] OP_REG_WRITE = 2'd2;

  // Configuration register indexes.
  localparam logic [7:0] CFG_SLAVE_ADDRESS = 8'd0;
  localparam logic [7:0] CFG_IDLE_TICKS    = 8'd1;

  // Configuration reset values.
  localparam logic [7:0] SLAVE_ADDRESS_RST = 8'd1;
  localparam logic [7:0] IDLE_TICKS_RST    = 8'd5;

  // Protocol constants.
  localparam logic [15:0] CRC_INIT        = 16'hFFFF;
  localparam logic [15:0] CRC_POLY        = 16'hA001;
  localparam logic [7:0]  ADDR_BROADCAST  = 8'h00;
  localparam logic [7:0]  FC_READ_HOLDING = 8'h03;
  localparam logic [7:0]  FC_EXC_FLAG     = 8'h80;
  localparam logic [15:0] MAX_READ_COUNT  = 16'd125;
  localparam int          HEADER_LEN      = 6;
  localparam logic [8:0]  MIN_FRAME_LEN   = 9'd4;
  localparam logic [8:0]  MIN_READ_LEN    = 9'd8;

  // Exception codes.
  localparam logic [7:0] EXC_ILLEGAL_FUNCTION = 8'h01;
  localparam logic [7:0] EXC_ILLEGAL_ADDRESS  = 8'h02;
  localparam logic [7:0] EXC_ILLEGAL_VALUE    = 8'h03;

  // Response sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_HEAD,
    ST_READ,
    ST_HIGH,
    ST_LOW,
    ST_CRC_LO,
    ST_CRC_HI
  } resp_state_t;

  // One byte of CRC-16, reflected polynomial, eight bit steps.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc_in, input logic [7:0] data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

/* hdl/mbrtu_in_if.sv */
// Input channel: received bytes, timer ticks and holding-register writes.
`timescale 1ns / 1ps
`default_nettype none
interface mbrtu_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [7:0]  rx_byte;
  logic [15:0] reg_index;
  logic [15:0] reg_value;

  modport source(output valid, output op, output rx_byte, output reg_index,
                 output reg_value, input ready);
  modport sink(input valid, input op, input rx_byte, input reg_index,
               input reg_value, output ready);
endinterface
`default_nettype wire

/* hdl/mbrtu_out_if.sv */
// Result channel: one response byte per word.
`timescale 1ns / 1ps
`default_nettype none
interface mbrtu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       last;

  modport source(output valid, output tx_byte, output last, input ready);
  modport sink(input valid, input tx_byte, input last, output ready);
endinterface
`default_nettype wire

/* hdl/mbrtu_cfg_if.sv */
// Configuration write channel: register index and write data.
`timescale 1ns / 1ps
`default_nettype none
interface mbrtu_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] index;
  logic [7:0] data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

/* hdl/modbus_rtu_read_holding_slave_core.sv */
// Received bytes, ticks and register writes are taken only while the sequencer is idle.
// A frame-ending tick enters a check state, then streams the response: an exception
// is 5 bytes, a read of N registers is 5+2N bytes, and each register goes through
// the single read port of the register RAM (read, high, low states).
// Outside the check and read states, one output word goes out per cycle while out_if.ready stays high.
// Reset (synchronous) clears the frame, the config to address 1 / 5 ticks, and the valid bits.
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_read_holding_slave_core #(
  parameter int NUM_REGS  = 16,
  parameter int RX_BUFFER = 64
) (
  input wire logic   clk,
  input wire logic   rst_n,
  mbrtu_in_if.sink   in_if,
  mbrtu_out_if.source out_if,
  mbrtu_cfg_if.sink  cfg_if
);

  localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
  localparam int CNT_W = $clog2(NUM_REGS + 1);
  localparam int FL_W  = $clog2(RX_BUFFER);
  localparam logic [FL_W-1:0] FL_MAX = FL_W'(RX_BUFFER - 1);

  // Configuration registers.
  logic [7:0] slave_addr_r;
  logic [7:0] idle_ticks_r;

  // Frame capture state.
  logic [FL_W-1:0] frame_len_r, frame_len_nxt;
  logic [7:0]      idle_cnt_r, idle_cnt_nxt;
  logic [5:0][7:0] hdr_r, hdr_nxt;
  logic [1:0][7:0] tail_r, tail_nxt;
  logic [15:0]     crc_lag_r, crc_lag_nxt;

  // Response sequencer state.
  mbrtu_pkg::resp_state_t state_r, state_nxt;
  logic [1:0]       hd_cnt_r, hd_cnt_nxt;
  logic             exc_r, exc_nxt;
  logic [7:0]       rsp_addr_r, rsp_addr_nxt;
  logic [7:0]       rsp_fc_r, rsp_fc_nxt;
  logic [7:0]       rsp_third_r, rsp_third_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic [15:0]      crc_tx_r, crc_tx_nxt;

  // Output register.
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic       out_last_r, out_last_nxt;

  // Register file: RAM plus one valid bit per entry.
  logic [NUM_REGS-1:0] reg_vld_r, reg_vld_nxt;
  logic                rd_vld_r, rd_vld_nxt;
  logic                ram_we;
  logic [IDX_W-1:0]    ram_waddr;
  logic                ram_re;
  logic [15:0]         ram_rdata;
  logic [15:0]         rd_word;

  // Handshake and frame check helpers.
  logic        in_fire;
  logic        slot_free;
  logic [7:0]  idle_inc;
  logic [15:0] req_start;
  logic [15:0] req_count;
  logic [16:0] req_end;
  logic        frame_drop;
  logic        load_en;
  logic        load_feed;
  logic [7:0]  load_byte;
  logic        load_last;

  assign in_if.ready  = (state_r == mbrtu_pkg::ST_IDLE);
  assign in_fire      = in_if.valid && in_if.ready;
  assign cfg_if.ready = 1'b1;
  assign slot_free    = !out_valid_r || out_if.ready;

  assign out_if.valid   = out_valid_r;
  assign out_if.tx_byte = out_byte_r;
  assign out_if.last    = out_last_r;

  assign idle_inc  = idle_cnt_r + 8'd1;
  assign req_start = {hdr_r[2], hdr_r[3]};
  assign req_count = {hdr_r[4], hdr_r[5]};
  assign req_end   = {1'b0, req_start} + {1'b0, req_count};
  assign rd_word   = rd_vld_r ? ram_rdata : 16'h0000;

  // A frame is dropped when short, when its CRC fails or when it is for another station.
  assign frame_drop = (9'(frame_len_r) < mbrtu_pkg::MIN_FRAME_LEN) ||
                      ({tail_r[1], tail_r[0]} != crc_lag_r) ||
                      ((hdr_r[0] != slave_addr_r) && (hdr_r[0] != mbrtu_pkg::ADDR_BROADCAST));

  // Register writes from the input channel go to the RAM when in range.
  assign ram_we    = in_fire && (in_if.op == mbrtu_pkg::OP_REG_WRITE) &&
                     (in_if.reg_index < 16'(NUM_REGS));
  assign ram_waddr = in_if.reg_index[IDX_W-1:0];
  assign ram_re    = (state_r == mbrtu_pkg::ST_READ);

  mbrtu_ram #(
    .WIDTH(16),
    .DEPTH(NUM_REGS)
  ) u_regs (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(in_if.reg_value),
    .re   (ram_re),
    .raddr(ptr_r),
    .rdata(ram_rdata)
  );

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= mbrtu_pkg::SLAVE_ADDRESS_RST;
      idle_ticks_r <= mbrtu_pkg::IDLE_TICKS_RST;
    end else if (cfg_if.valid && cfg_if.ready) begin
      case (cfg_if.index)
        mbrtu_pkg::CFG_SLAVE_ADDRESS: slave_addr_r <= cfg_if.data;
        mbrtu_pkg::CFG_IDLE_TICKS:    idle_ticks_r <= cfg_if.data;
        default: ;
      endcase
    end
  end

  // Next state: frame capture, frame check and response sequencing.
  always_comb begin
    state_nxt     = state_r;
    frame_len_nxt = frame_len_r;
    idle_cnt_nxt  = idle_cnt_r;
    hdr_nxt       = hdr_r;
    tail_nxt      = tail_r;
    crc_lag_nxt   = crc_lag_r;
    hd_cnt_nxt    = hd_cnt_r;
    exc_nxt       = exc_r;
    rsp_addr_nxt  = rsp_addr_r;
    rsp_fc_nxt    = rsp_fc_r;
    rsp_third_nxt = rsp_third_r;
    ptr_nxt       = ptr_r;
    remain_nxt    = remain_r;
    crc_tx_nxt    = crc_tx_r;
    reg_vld_nxt   = reg_vld_r;
    rd_vld_nxt    = rd_vld_r;
    load_en       = 1'b0;
    load_feed     = 1'b0;
    load_byte     = 8'h00;
    load_last     = 1'b0;

    case (state_r)
      mbrtu_pkg::ST_IDLE: begin
        if (in_fire) begin
          case (in_if.op)
            mbrtu_pkg::OP_RX_BYTE: begin
              // Bytes past the buffer are dropped and leave the idle count alone.
              if (frame_len_r < FL_MAX) begin
                if (9'(frame_len_r) < 9'(mbrtu_pkg::HEADER_LEN)) begin
                  hdr_nxt[frame_len_r[2:0]] = in_if.rx_byte;
                end
                if (9'(frame_len_r) >= 9'd2) begin
                  crc_lag_nxt = mbrtu_pkg::crc_feed(crc_lag_r, tail_r[0]);
                  tail_nxt[0] = tail_r[1];
                  tail_nxt[1] = in_if.rx_byte;
                end else begin
                  tail_nxt[frame_len_r[0]] = in_if.rx_byte;
                end
                frame_len_nxt = frame_len_r + FL_W'(1);
                idle_cnt_nxt  = 8'd0;
              end
            end
            mbrtu_pkg::OP_TICK: begin
              if (frame_len_r != '0) begin
                if (idle_inc >= idle_ticks_r) begin
                  idle_cnt_nxt = 8'd0;
                  state_nxt    = mbrtu_pkg::ST_EVAL;
                end else begin
                  idle_cnt_nxt = idle_inc;
                end
              end else begin
                idle_cnt_nxt = 8'd0;
              end
            end
            mbrtu_pkg::OP_REG_WRITE: begin
              if (ram_we) begin
                reg_vld_nxt[ram_waddr] = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      mbrtu_pkg::ST_EVAL: begin
        // The frame ends here whatever the outcome.
        frame_len_nxt = '0;
        idle_cnt_nxt  = 8'd0;
        crc_lag_nxt   = mbrtu_pkg::CRC_INIT;
        rsp_addr_nxt  = hdr_r[0];
        crc_tx_nxt    = mbrtu_pkg::CRC_INIT;
        hd_cnt_nxt    = 2'd0;
        exc_nxt       = 1'b1;
        rsp_fc_nxt    = hdr_r[1] | mbrtu_pkg::FC_EXC_FLAG;
        rsp_third_nxt = mbrtu_pkg::EXC_ILLEGAL_VALUE;
        ptr_nxt       = req_start[IDX_W-1:0];
        remain_nxt    = req_count[CNT_W-1:0];
        if (frame_drop) begin
          state_nxt = mbrtu_pkg::ST_IDLE;
        end else begin
          state_nxt = mbrtu_pkg::ST_HEAD;
          if (hdr_r[1] != mbrtu_pkg::FC_READ_HOLDING) begin
            rsp_third_nxt = mbrtu_pkg::EXC_ILLEGAL_FUNCTION;
          end else if (9'(frame_len_r) < mbrtu_pkg::MIN_READ_LEN) begin
            rsp_third_nxt = mbrtu_pkg::EXC_ILLEGAL_VALUE;
          end else if (req_end > 17'(NUM_REGS)) begin
            rsp_third_nxt = mbrtu_pkg::EXC_ILLEGAL_ADDRESS;
          end else if ((req_count == 16'd0) || (req_count > mbrtu_pkg::MAX_READ_COUNT)) begin
            rsp_third_nxt = mbrtu_pkg::EXC_ILLEGAL_VALUE;
          end else begin
            exc_nxt       = 1'b0;
            rsp_fc_nxt    = mbrtu_pkg::FC_READ_HOLDING;
            rsp_third_nxt = {hdr_r[5][6:0], 1'b0};
          end
        end
      end

      mbrtu_pkg::ST_HEAD: begin
        // Address, function and byte count or exception code.
        if (slot_free) begin
          load_en   = 1'b1;
          load_feed = 1'b1;
          case (hd_cnt_r)
            2'd0:    load_byte = rsp_addr_r;
            2'd1:    load_byte = rsp_fc_r;
            default: load_byte = rsp_third_r;
          endcase
          if (hd_cnt_r == 2'd2) begin
            state_nxt = exc_r ? mbrtu_pkg::ST_CRC_LO : mbrtu_pkg::ST_READ;
          end else begin
            hd_cnt_nxt = hd_cnt_r + 2'd1;
          end
        end
      end

      mbrtu_pkg::ST_READ: begin
        // RAM read issued this cycle; data arrives in the next.
        rd_vld_nxt = reg_vld_r[ptr_r];
        state_nxt  = mbrtu_pkg::ST_HIGH;
      end

      mbrtu_pkg::ST_HIGH: begin
        if (slot_free) begin
          load_en   = 1'b1;
          load_feed = 1'b1;
          load_byte = rd_word[15:8];
          state_nxt = mbrtu_pkg::ST_LOW;
        end
      end

      mbrtu_pkg::ST_LOW: begin
        if (slot_free) begin
          load_en    = 1'b1;
          load_feed  = 1'b1;
          load_byte  = rd_word[7:0];
          ptr_nxt    = ptr_r + IDX_W'(1);
          remain_nxt = remain_r - CNT_W'(1);
          state_nxt  = (remain_r == CNT_W'(1)) ? mbrtu_pkg::ST_CRC_LO : mbrtu_pkg::ST_READ;
        end
      end

      mbrtu_pkg::ST_CRC_LO: begin
        if (slot_free) begin
          load_en   = 1'b1;
          load_byte = crc_tx_r[7:0];
          state_nxt = mbrtu_pkg::ST_CRC_HI;
        end
      end

      mbrtu_pkg::ST_CRC_HI: begin
        if (slot_free) begin
          load_en   = 1'b1;
          load_byte = crc_tx_r[15:8];
          load_last = 1'b1;
          state_nxt = mbrtu_pkg::ST_IDLE;
        end
      end

      default: state_nxt = mbrtu_pkg::ST_IDLE;
    endcase

    // Running CRC over the response bytes.
    if (load_en && load_feed) begin
      crc_tx_nxt = mbrtu_pkg::crc_feed(crc_tx_r, load_byte);
    end

    // Output register: load a new word or drop the one just taken.
    out_valid_nxt = out_valid_r && !out_if.ready;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (load_en) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = load_byte;
      out_last_nxt  = load_last;
    end
  end

  // Control registers with reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= mbrtu_pkg::ST_IDLE;
      frame_len_r <= '0;
      idle_cnt_r  <= 8'd0;
      hdr_r       <= '0;
      tail_r      <= '0;
      crc_lag_r   <= mbrtu_pkg::CRC_INIT;
      reg_vld_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      frame_len_r <= frame_len_nxt;
      idle_cnt_r  <= idle_cnt_nxt;
      hdr_r       <= hdr_nxt;
      tail_r      <= tail_nxt;
      crc_lag_r   <= crc_lag_nxt;
      reg_vld_r   <= reg_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers of the sequencer and output stage.
  always_ff @(posedge clk) begin
    hd_cnt_r    <= hd_cnt_nxt;
    exc_r       <= exc_nxt;
    rsp_addr_r  <= rsp_addr_nxt;
    rsp_fc_r    <= rsp_fc_nxt;
    rsp_third_r <= rsp_third_nxt;
    ptr_r       <= ptr_nxt;
    remain_r    <= remain_nxt;
    crc_tx_r    <= crc_tx_nxt;
    rd_vld_r    <= rd_vld_nxt;
    out_byte_r  <= out_byte_nxt;
    out_last_r  <= out_last_nxt;
  end

  // The frame buffer count never passes its limit.
  a_frame_len_limit: assert property (@(posedge clk) disable iff (!rst_n)
    frame_len_r <= FL_MAX)
    else $error("frame length beyond buffer limit");

  // The check cycle always restarts frame capture.
  a_eval_clears_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mbrtu_pkg::ST_EVAL) |=>
      (frame_len_r == '0) && (crc_lag_r == mbrtu_pkg::CRC_INIT))
    else $error("frame state not cleared after frame check");

  // Register reads stay inside the register file.
  a_read_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == mbrtu_pkg::ST_READ) |-> (32'(ptr_r) < NUM_REGS))
    else $error("register read address out of range");

  // The final CRC byte closes the response and frees the input.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == mbrtu_pkg::ST_CRC_HI) && slot_free) |=>
      (out_valid_r && out_last_r && (state_r == mbrtu_pkg::ST_IDLE)))
    else $error("final response byte not marked last");

endmodule
`default_nettype wire

/* hdl/mbrtu_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module mbrtu_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
